@@ hdl/hmap_pkg.sv @@
// Shared types and constants for the bounded-way hash map.
package hmap_pkg;

  // Geometry: BUCKETS must be a power of two, the bucket is the low key bits
  localparam int unsigned BUCKETS = 1024;
  localparam int unsigned WAYS    = 4;
  localparam int unsigned KEY_W   = 31;
  localparam int unsigned VAL_W   = 31;
  localparam int unsigned BKT_W   = $clog2(BUCKETS);
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SLOT_W  = 1 + KEY_W + VAL_W;
  localparam int unsigned ROW_W   = WAYS * SLOT_W;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  typedef slot_t [WAYS-1:0] row_t;

  // Outcome of one bucket lookup/update
  typedef struct packed {
    logic wr_en;
    row_t wr_row;
    rsp_t rsp;
  } bkt_res_t;

endpackage

@@ hdl/hash_map_put_get_remove.sv @@
// Top level of the key-to-value map with bounded ways per bucket.
//
// Requests enter on in_valid_i/in_ready_o with in_req_i (opcode, key, value);
// one response per request leaves on out_valid_o/out_ready_i with out_rsp_o
// (status, read_value), in request order.
// The bucket is the low key bits; its whole row (all ways) sits in one word
// of a synchronous RAM. A request reads its row at acceptance; in the lookup
// stage all ways are compared in parallel, and when that stage fires the row is
// written back and the response register loads. Throughput is one request
// per cycle while the output is not stalled: a request that reads the row being
// written in the same cycle takes the new row from a forwarding register.
// When out_ready_i is low the response holds in the output register; one more
// request waits in the lookup stage, and then in_ready_o drops.
// After reset a clearing pass writes every row to empty, one row per cycle,
// through all BUCKETS (1024) rows; in_ready_o stays low during that pass.
module hash_map_put_get_remove (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hmap_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hmap_pkg::rsp_t out_rsp_o
);

  logic                       clr_q;
  logic [hmap_pkg::BKT_W-1:0] clr_cnt_q;
  logic                       s1_valid_q;
  hmap_pkg::req_t             s1_req_q;
  logic                       fwd_q;
  hmap_pkg::row_t             fwd_row_q;
  logic                       out_valid_q;
  hmap_pkg::rsp_t             out_rsp_q;

  logic                       s1_fire;
  logic                       in_fire;
  logic [hmap_pkg::BKT_W-1:0] in_bkt;
  logic [hmap_pkg::BKT_W-1:0] s1_bkt;
  logic [hmap_pkg::ROW_W-1:0] ram_rdata;
  hmap_pkg::row_t             s1_row;
  hmap_pkg::bkt_res_t         res;
  logic                       ram_we;
  logic [hmap_pkg::BKT_W-1:0] ram_waddr;
  logic [hmap_pkg::ROW_W-1:0] ram_wdata;

  // Handshake
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_q && (!s1_valid_q || s1_fire);
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_bkt = in_req_i.key[hmap_pkg::BKT_W-1:0];
  assign s1_bkt = s1_req_q.key[hmap_pkg::BKT_W-1:0];

  // Row seen by the lookup stage: forwarded if written as it was read
  assign s1_row = fwd_q ? fwd_row_q : hmap_pkg::row_t'(ram_rdata);

  hmap_bucket u_bucket (
    .req_i (s1_req_q),
    .row_i (s1_row),
    .res_o (res)
  );

  // Write port: clearing pass or write-back
  assign ram_we    = clr_q || (s1_fire && res.wr_en);
  assign ram_waddr = clr_q ? clr_cnt_q : s1_bkt;
  assign ram_wdata = clr_q ? '0 : hmap_pkg::ROW_W'(res.wr_row);

  hmap_ram #(
    .DEPTH (hmap_pkg::BUCKETS),
    .WIDTH (hmap_pkg::ROW_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (in_bkt),
    .rdata_o (ram_rdata)
  );

  // Clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == hmap_pkg::BKT_W'(hmap_pkg::BUCKETS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Lookup stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_fire && res.wr_en && (in_bkt == s1_bkt);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q  <= in_req_i;
      fwd_row_q <= res.wr_row;
    end
    if (s1_fire) begin
      out_rsp_q <= res.rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

@@ hdl/hmap_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module hmap_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 252
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/hmap_bucket.sv @@
// Compares all ways of one bucket row with the key and builds the updated row.
module hmap_bucket (
  input  hmap_pkg::req_t     req_i,
  input  hmap_pkg::row_t     row_i,
  output hmap_pkg::bkt_res_t res_o
);

  logic [hmap_pkg::WAYS-1:0]  hit_vec;
  logic [hmap_pkg::WAYS-1:0]  free_vec;
  logic [hmap_pkg::WAY_W-1:0] hit_idx;
  logic [hmap_pkg::WAY_W-1:0] free_idx;

  // Parallel compare, lowest-numbered way wins
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < int'(hmap_pkg::WAYS); w++) begin
      hit_vec[w]  = row_i[w].used && (row_i[w].key == req_i.key);
      free_vec[w] = !row_i[w].used;
    end
    for (int w = int'(hmap_pkg::WAYS) - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_idx = hmap_pkg::WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_idx = hmap_pkg::WAY_W'(w);
      end
    end
  end

  // Row update and response
  always_comb begin
    res_o.wr_en          = 1'b0;
    res_o.wr_row         = row_i;
    res_o.rsp.status     = hmap_pkg::ST_DONE;
    res_o.rsp.read_value = '0;
    case (hmap_pkg::op_e'(req_i.opcode))
      hmap_pkg::OP_PUT: begin
        if (|hit_vec) begin
          res_o.wr_en                  = 1'b1;
          res_o.wr_row[hit_idx].value  = req_i.value;
        end else if (|free_vec) begin
          res_o.wr_en                  = 1'b1;
          res_o.wr_row[free_idx].used  = 1'b1;
          res_o.wr_row[free_idx].key   = req_i.key;
          res_o.wr_row[free_idx].value = req_i.value;
        end else begin
          res_o.rsp.status = hmap_pkg::ST_FULL;
        end
      end
      hmap_pkg::OP_REMOVE: begin
        if (|hit_vec) begin
          res_o.wr_en                = 1'b1;
          res_o.wr_row[hit_idx].used = 1'b0;
        end else begin
          res_o.rsp.status = hmap_pkg::ST_ABSENT;
        end
      end
      hmap_pkg::OP_GET: begin
        if (|hit_vec) begin
          res_o.rsp.read_value = row_i[hit_idx].value;
        end else begin
          res_o.rsp.status = hmap_pkg::ST_ABSENT;
        end
      end
      default: begin
        // unused opcode: no change, done, zero value
      end
    endcase
  end

endmodule

@@ hdl/hmap_checker.sv @@
// Port-level checks for the hash map, bound to the top level.
module hmap_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input hmap_pkg::rsp_t out_rsp_o
);

  // Status is one of the defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.status <= hmap_pkg::ST_FULL))
    else $error("response status uses unused code");

  // A response that is not done carries a zero value
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status != hmap_pkg::ST_DONE)) |->
      (out_rsp_o.read_value == '0))
    else $error("nonzero value on a response that is not done");

  // A new response follows an accepted request, checked through $past
  a_rsp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("response without a matching request");

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("stalled response changed or dropped");

endmodule

bind hash_map_put_get_remove hmap_checker u_hmap_checker (.*);
